/* rtl/pav_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pav_pkg: shared types and constants for the principal axis vector rotator
// Working formats, lane record handed along the CORDIC row, arctangent table
// and the gain constant.
// ----------------------------------------------------------------------------
package pav_pkg;

  // Working width of the rotated pair: 32 fraction bits, headroom for the
  // CORDIC growth of a full-scale Q16.16 input.
  localparam int WORK_W = 50;
  // Angle accumulator, units of pi / 2^31, with guard bits.
  localparam int Z_W    = 34;
  localparam int PROD_W = 64;
  localparam int MAX_STAGES = 24;

  typedef enum logic [1:0] {
    AXIS_X   = 2'd0,
    AXIS_Y   = 2'd1,
    AXIS_Z   = 2'd2,
    AXIS_BAD = 2'd3
  } axis_t;

  // Record carried through each CORDIC cell.
  typedef struct packed {
    logic signed [WORK_W-1:0] a;
    logic signed [WORK_W-1:0] b;
    logic signed [Z_W-1:0]    z;
    logic signed [31:0]       pass;
    axis_t                    axis;
  } lane_t;

  // round(atan(2^-i) * 2^31 / pi)
  localparam logic [29:0] ATAN_TAB [MAX_STAGES] = '{
    30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
    30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
    30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
    30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
    30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051
  };

  // Stage count clamped to at least 8 and at most the table size.
  function automatic int clamp_stages(int n);
    int r;
    r = n;
    if (r < 8) r = 8;
    if (r > MAX_STAGES) r = MAX_STAGES;
    return r;
  endfunction

  // Inverse CORDIC gain in Q1.31 for n stages.
  function automatic logic signed [31:0] cordic_gain(int n);
    longint num;
    longint k;
    num = 64'sd869377166 + (64'sd1 <<< (2 * n - 1));
    k   = 64'sd1304065748 + (num >>> (2 * n));
    return k[31:0];
  endfunction

endpackage

/* rtl/pav_prep.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pav_prep: operand selection, quadrant fold and gain pre-scale
// Two registered stages: pair select and gain multiply, then sign fix and
// scaling into the working format.
// ----------------------------------------------------------------------------
module pav_prep #(
  parameter int STAGES = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  logic signed [15:0]    angle,
  input  logic [1:0]            axis,
  input  logic signed [31:0]    vec_x,
  input  logic signed [31:0]    vec_y,
  input  logic signed [31:0]    vec_z,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output pav_pkg::lane_t        dn_lane
);
  import pav_pkg::*;

  localparam logic signed [31:0] KGAIN = cordic_gain(clamp_stages(STAGES));

  typedef struct packed {
    logic signed [PROD_W-1:0] pa;
    logic signed [PROD_W-1:0] pb;
    logic signed [Z_W-1:0]    z;
    logic signed [31:0]       pass;
    axis_t                    axis;
    logic                     neg;
  } prod_t;

  axis_t              ax;
  logic signed [31:0] ra;
  logic signed [31:0] rb;
  logic signed [31:0] rp;
  logic signed [16:0] ang;
  logic               neg_next;
  prod_t              prod_next;
  prod_t              prod;
  logic               vld1;
  logic               rdy1;
  logic               rdy2;
  logic signed [PROD_W-1:0] na;
  logic signed [PROD_W-1:0] nb;
  lane_t              lane_next;

  assign ax = axis_t'(axis);

  always_comb begin
    unique case (ax)
      AXIS_X: begin
        ra = vec_y; rb = vec_z; rp = vec_x;
      end
      AXIS_Y: begin
        ra = vec_z; rb = vec_x; rp = vec_y;
      end
      default: begin
        ra = vec_x; rb = vec_y; rp = vec_z;
      end
    endcase
  end

  // Fold angles beyond +-pi/2 by a half turn: negate the pair instead.
  always_comb begin
    ang      = 17'(angle);
    neg_next = 1'b0;
    if (angle > 16'sd16384) begin
      ang      = 17'(angle) - 17'sd32768;
      neg_next = 1'b1;
    end else if (angle < -16'sd16384) begin
      ang      = 17'(angle) + 17'sd32768;
      neg_next = 1'b1;
    end
  end

  always_comb begin
    prod_next.z    = Z_W'(ang) <<< 16;
    prod_next.pass = rp;
    prod_next.axis = ax;
    prod_next.neg  = neg_next;
    if (ax == AXIS_BAD) begin
      // raw operands ride along untouched
      prod_next.pa = PROD_W'(ra);
      prod_next.pb = PROD_W'(rb);
    end else begin
      prod_next.pa = ra * KGAIN;
      prod_next.pb = rb * KGAIN;
    end
  end

  assign rdy1     = !vld1 || rdy2;
  assign rdy2     = !dn_valid || dn_ready;
  assign up_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (rdy1) begin
      vld1 <= up_valid;
    end
    if (rdy1 && up_valid) begin
      prod <= prod_next;
    end
  end

  always_comb begin
    na = prod.neg ? -prod.pa : prod.pa;
    nb = prod.neg ? -prod.pb : prod.pb;
    lane_next.z    = prod.z;
    lane_next.pass = prod.pass;
    lane_next.axis = prod.axis;
    if (prod.axis == AXIS_BAD) begin
      lane_next.a = WORK_W'(prod.pa <<< 16);
      lane_next.b = WORK_W'(prod.pb <<< 16);
    end else begin
      lane_next.a = WORK_W'(na >>> 15);
      lane_next.b = WORK_W'(nb >>> 15);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (rdy2) begin
      dn_valid <= vld1;
    end
    if (rdy2 && vld1) begin
      dn_lane <= lane_next;
    end
  end

endmodule

/* rtl/pav_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pav_cell: one CORDIC micro-rotation
// Rotates the pair by +-atan(2^-IDX) toward zero residual angle, passes
// bad-axis lanes unchanged and registers the result for the next cell.
// ----------------------------------------------------------------------------
module pav_cell #(
  parameter int IDX = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           up_valid,
  output logic           up_ready,
  input  pav_pkg::lane_t up_lane,
  output logic           dn_valid,
  input  logic           dn_ready,
  output pav_pkg::lane_t dn_lane
);
  import pav_pkg::*;

  localparam logic signed [Z_W-1:0] STEP = Z_W'(ATAN_TAB[IDX]);

  logic signed [WORK_W-1:0] da;
  logic signed [WORK_W-1:0] db;
  lane_t                    lane_next;

  assign da = up_lane.b >>> IDX;
  assign db = up_lane.a >>> IDX;

  always_comb begin
    lane_next = up_lane;
    if (up_lane.axis != AXIS_BAD) begin
      if (!up_lane.z[Z_W-1]) begin
        lane_next.a = up_lane.a - da;
        lane_next.b = up_lane.b + db;
        lane_next.z = up_lane.z - STEP;
      end else begin
        lane_next.a = up_lane.a + da;
        lane_next.b = up_lane.b - db;
        lane_next.z = up_lane.z + STEP;
      end
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      dn_lane <= lane_next;
    end
  end

endmodule

/* rtl/pav_finish.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pav_finish: rounding, saturation and output register
// Rounds the pair back to Q16.16, clamps to 32 bits, routes the three
// components to their axes and holds the result until taken.
// ----------------------------------------------------------------------------
module pav_finish (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_ready,
  input  pav_pkg::lane_t     up_lane,
  output logic               result_valid,
  input  logic               result_ready,
  output logic signed [31:0] rot_x,
  output logic signed [31:0] rot_y,
  output logic signed [31:0] rot_z,
  output logic               saturated,
  output logic               bad_axis
);
  import pav_pkg::*;

  localparam int R_W = WORK_W - 16;

  logic signed [WORK_W-1:0] sum_a;
  logic signed [WORK_W-1:0] sum_b;
  logic signed [R_W-1:0]    ra;
  logic signed [R_W-1:0]    rb;
  logic                     ovf_a;
  logic                     ovf_b;
  logic signed [31:0]       ca;
  logic signed [31:0]       cb;
  logic signed [31:0]       x_next;
  logic signed [31:0]       y_next;
  logic signed [31:0]       z_next;

  assign sum_a = up_lane.a + WORK_W'(32768);
  assign sum_b = up_lane.b + WORK_W'(32768);
  assign ra    = R_W'(sum_a >>> 16);
  assign rb    = R_W'(sum_b >>> 16);

  // in range iff the bits above bit 30 are all sign
  assign ovf_a = !((&ra[R_W-1:31]) || !(|ra[R_W-1:31]));
  assign ovf_b = !((&rb[R_W-1:31]) || !(|rb[R_W-1:31]));
  assign ca = ovf_a ? (ra[R_W-1] ? 32'sh80000000 : 32'sh7FFFFFFF) : ra[31:0];
  assign cb = ovf_b ? (rb[R_W-1] ? 32'sh80000000 : 32'sh7FFFFFFF) : rb[31:0];

  always_comb begin
    unique case (up_lane.axis)
      AXIS_X: begin
        x_next = up_lane.pass; y_next = ca; z_next = cb;
      end
      AXIS_Y: begin
        z_next = ca; x_next = cb; y_next = up_lane.pass;
      end
      default: begin
        x_next = ca; y_next = cb; z_next = up_lane.pass;
      end
    endcase
  end

  assign up_ready = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (up_ready) begin
      result_valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      rot_x     <= x_next;
      rot_y     <= y_next;
      rot_z     <= z_next;
      saturated <= ovf_a || ovf_b;
      bad_axis  <= (up_lane.axis == AXIS_BAD);
    end
  end

endmodule

/* rtl/principal_axis_vector_rotate.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// principal_axis_vector_rotate: rotate a Q16.16 vector about X, Y or Z
// Pipelined CORDIC rotator; one vector per clock while result_ready is held high.
// ----------------------------------------------------------------------------
// Usage:
//   Item channel (item_valid/item_ready) takes angle, axis and vec_x/y/z.
//   Result channel (result_valid/result_ready) gives rot_x/y/z, saturated
//   and bad_axis. Both channels use a valid/ready transaction.
//   The vector is turned by angle (32768 = pi) about the chosen axis; the
//   component along the axis passes through. Axis code 3 returns the
//   vector unchanged with bad_axis set.
//   Stages: two prescale stages, one cell per CORDIC iteration and one
//   output register.
//   Throughput: one transaction per cycle while result_ready stays high;
//   each stage holds one item; the cell row sets the rate, one micro-rotation per cell.
//   Stall: when result_ready is low the output register holds its result;
//   earlier stages keep filling until every stage holds an item, then
//   item_ready drops.
//   Reset: synchronous, clears all stage valids; no clearing pass.
// ----------------------------------------------------------------------------
module principal_axis_vector_rotate #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic signed [15:0] angle,
  input  logic [1:0]         axis,
  input  logic signed [31:0] vec_x,
  input  logic signed [31:0] vec_y,
  input  logic signed [31:0] vec_z,
  output logic               result_valid,
  input  logic               result_ready,
  output logic signed [31:0] rot_x,
  output logic signed [31:0] rot_y,
  output logic signed [31:0] rot_z,
  output logic               saturated,
  output logic               bad_axis
);
  import pav_pkg::*;

  localparam int N = clamp_stages(CORDIC_STAGES);

  logic [N:0] vld;
  logic [N:0] rdy;
  lane_t      lanes [N+1];

  pav_prep #(
    .STAGES (CORDIC_STAGES)
  ) u_prep (
    .clk      (clk),
    .rst      (rst),
    .up_valid (item_valid),
    .up_ready (item_ready),
    .angle    (angle),
    .axis     (axis),
    .vec_x    (vec_x),
    .vec_y    (vec_y),
    .vec_z    (vec_z),
    .dn_valid (vld[0]),
    .dn_ready (rdy[0]),
    .dn_lane  (lanes[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    pav_cell #(
      .IDX (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (vld[i]),
      .up_ready (rdy[i]),
      .up_lane  (lanes[i]),
      .dn_valid (vld[i+1]),
      .dn_ready (rdy[i+1]),
      .dn_lane  (lanes[i+1])
    );
  end

  pav_finish u_finish (
    .clk          (clk),
    .rst          (rst),
    .up_valid     (vld[N]),
    .up_ready     (rdy[N]),
    .up_lane      (lanes[N]),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .rot_x        (rot_x),
    .rot_y        (rot_y),
    .rot_z        (rot_z),
    .saturated    (saturated),
    .bad_axis     (bad_axis)
  );

  // A pass-through vector never clamps.
  a_bad_no_sat: assert property (@(posedge clk) disable iff (rst)
    result_valid && bad_axis |-> !saturated)
    else $error("saturated set on invalid axis result");

  // With the output register empty nothing downstream can block the input.
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> item_ready)
    else $error("item_ready low while output register empty");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result_valid set after reset");

  // A result cannot appear directly out of a pipe whose prep output, cells and output register are all empty.
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    !result_valid && !(|vld) |=> !result_valid)
    else $error("result appeared with empty pipeline");

endmodule
